@@ src/cpds_pkg.sv @@
package cpds_pkg;

  localparam int FRACB = 30;
  localparam logic [63:0] ONE_Q30 = 64'd1 << FRACB;

  // Floor square root, two radicand bits per step.
  function automatic logic [63:0] isqrt64(input logic [63:0] val);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    int i;
    v = val;
    r = '0;
    b = 64'd1 << 62;
    for (i = 0; i < 32; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^(-2^-j) in Q30.
  function automatic logic [30:0] root_half(input int j);
    logic [63:0] r;
    int i;
    r = ONE_Q30;
    if (j >= 1) begin
      r = isqrt64(64'd1 << (2 * FRACB - 1));
    end
    for (i = 2; i <= j; i++) begin
      r = isqrt64(r << FRACB);
    end
    return r[30:0];
  endfunction

  // Cosine or sine of a turn of 2*pi/2^k in Q30, two's complement.
  function automatic logic [63:0] turn_val(input int k, input logic want_sin);
    logic [63:0] c;
    logic [63:0] cn;
    logic [63:0] sn;
    int i;
    c  = '0;
    cn = ONE_Q30;
    sn = '0;
    if (k == 1) begin
      cn = 64'd0 - ONE_Q30;
    end else if (k >= 2) begin
      cn = '0;
      sn = ONE_Q30;
      for (i = 3; i <= k; i++) begin
        cn = isqrt64((ONE_Q30 + c) << (FRACB - 1));
        sn = isqrt64((ONE_Q30 - c) << (FRACB - 1));
        c  = cn;
      end
    end
    return want_sin ? sn : cn;
  endfunction

  // Round a Q60 product to Q30, half away from zero.
  function automatic logic signed [33:0] round_q30(input logic signed [63:0] x);
    logic        neg;
    logic [63:0] mag;
    logic [33:0] r;
    neg = x[63];
    mag = neg ? (64'd0 - x) : x;
    mag = (mag + (64'd1 << (FRACB - 1))) >> FRACB;
    r   = mag[33:0];
    return neg ? (34'd0 - r) : r;
  endfunction

endpackage

@@ src/cosine_power_direction_sampler.sv @@
// Cosine-power lobe direction sampler.
// Slave stream in_*: one transfer carries uniform_azimuth (rx), uniform_elevation (ry)
// and lobe_exponent (e, Q8.8). Master stream out_*: one transfer per input carries the
// unit direction (dir_x, dir_y signed Q1.15, dir_z unsigned) in a cos^e lobe about +z.
// The datapath is a fully pipelined chain: normalize, 30 log squaring stages, a
// restoring divider by e+256 (one quotient bit per stage), 30 exp multiply stages,
// a round shift, a 31-stage square root, then the sin/cos products and rounding.
// The azimuth rotation (two stages per bit of rx) runs beside it and is delayed to meet.
// Throughput: one item per cycle while the skid register is empty, set by the single
// global stage enable.
// Reset clears all valid bits and the skid register's valid flag; no table needs a fill.
// When the receiver stalls, the last result drops into a skid register and the whole
// pipeline holds until it drains; in_tready then falls for as long as the skid is full.
// Results leave in input order, none lost or repeated.
module cosine_power_direction_sampler #(
  parameter int UNIFORM_BITS = 16,
  parameter int OUT_BITS     = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // uniform_azimuth, uniform_elevation, lobe_exponent[15:0], zero pad
  input  logic [((2*UNIFORM_BITS+16+7)/8)*8-1:0] in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  // dir_x, dir_y, dir_z[OUT_BITS-2:0], zero pad
  output logic [((3*OUT_BITS-1+7)/8)*8-1:0]      out_tdata
);

  localparam int UB    = UNIFORM_BITS;
  localparam int OB    = OUT_BITS;
  localparam int UW    = UB + 1;
  localparam int PW    = $clog2(UB + 1);
  localparam int LW    = PW + 30;
  localparam int NW    = (UW > 31) ? UW : 31;
  localparam int OUT_W = ((3*OB-1+7)/8)*8;
  localparam int LOGN  = 30;
  localparam int EXPN  = 30;
  localparam int RTN   = 31;
  localparam int N_RT  = 1 + 1 + LOGN + (LW + 1) + EXPN + 1 + 1 + RTN;
  localparam int N_OUT = N_RT + 3;
  localparam int N_ANG = 1 + 2*UB;
  localparam int ADLY  = N_RT - N_ANG;
  localparam int SH    = 31 - OB;
  localparam int SHR   = (SH > 0) ? SH : 1;
  localparam int SHL   = (SH < 0) ? -SH : 0;
  localparam logic [35:0] LIM = 36'd1 << (OB - 1);
  localparam logic [LW-1:0] L_TOP = LW'(UB) << 30;
  localparam logic [30:0] ONE31 = 31'd1 << 30;

  function automatic logic [OB-1:0] to_out(input logic signed [33:0] q);
    logic        neg;
    logic [35:0] mag;
    neg = q[33];
    mag = {2'b00, (neg ? (34'd0 - q) : q)};
    if (SH > 0) begin
      mag = (mag + (36'd1 << (SHR - 1))) >> SHR;
    end else begin
      mag = mag << SHL;
    end
    if (neg) begin
      if (mag > LIM) mag = LIM;
      mag = 36'd0 - mag;
    end else if (mag > LIM - 36'd1) begin
      mag = LIM - 36'd1;
    end
    return mag[OB-1:0];
  endfunction

  // Global stage enable: advance unless the skid register is holding a result.
  logic pipe_en;
  logic skid_v_r;
  logic [N_OUT-1:0] v_r;

  assign pipe_en   = !skid_v_r;
  assign in_tready = pipe_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (pipe_en) begin
      v_r <= {v_r[N_OUT-2:0], in_tvalid};
    end
  end

  // Input register
  logic [UB-1:0] rx0_r, ry0_r;
  logic [15:0]   e0_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      rx0_r <= in_tdata[UB-1:0];
      ry0_r <= in_tdata[2*UB-1:UB];
      e0_r  <= in_tdata[2*UB+15 -: 16];
    end
  end

  // Normalize u = 2^UB - ry to a Q30 mantissa and its exponent.
  logic [UW-1:0] nm_u;
  logic [PW-1:0] nm_p;
  logic [NW-1:0] nm_wide;
  logic [30:0]   nm_m_r;
  logic [PW-1:0] nm_p_r;
  logic [15:0]   nm_e_r;

  always_comb begin
    nm_u = {1'b1, {UB{1'b0}}} - {1'b0, ry0_r};
    nm_p = '0;
    for (int b = 0; b < UW; b++) begin
      if (nm_u[b]) nm_p = PW'(b);
    end
    nm_wide = NW'(nm_u) << (NW - 1 - int'(nm_p));
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      nm_m_r <= nm_wide[NW-1 -: 31];
      nm_p_r <= nm_p;
      nm_e_r <= e0_r;
    end
  end

  // Log2 fraction, one bit per squaring stage.
  logic [30:0]   lg_m_r [LOGN];
  logic [29:0]   lg_f_r [LOGN];
  logic [PW-1:0] lg_p_r [LOGN];
  logic [15:0]   lg_e_r [LOGN];

  for (genvar g = 0; g < LOGN; g++) begin : g_log
    logic [30:0]   m_in;
    logic [29:0]   f_in;
    logic [PW-1:0] p_in;
    logic [15:0]   e_in;
    logic [61:0]   sq;
    if (g == 0) begin : g_first
      assign m_in = nm_m_r;
      assign f_in = '0;
      assign p_in = nm_p_r;
      assign e_in = nm_e_r;
    end else begin : g_next
      assign m_in = lg_m_r[g-1];
      assign f_in = lg_f_r[g-1];
      assign p_in = lg_p_r[g-1];
      assign e_in = lg_e_r[g-1];
    end
    assign sq = 62'(m_in) * 62'(m_in);
    always_ff @(posedge clk) begin
      if (pipe_en) begin
        lg_m_r[g] <= sq[61] ? sq[61:31] : sq[60:30];
        lg_f_r[g] <= {f_in[28:0], sq[61]};
        lg_p_r[g] <= p_in;
        lg_e_r[g] <= e_in;
      end
    end
  end

  // Divide L*256 by e+256: index 0 loads, then one quotient bit per stage.
  logic [16:0]   dv_rem_r [LW+1];
  logic [LW-1:0] dv_num_r [LW+1];
  logic [LW-1:0] dv_q_r   [LW+1];
  logic [16:0]   dv_d_r   [LW+1];
  logic [LW-1:0] dv_l;

  assign dv_l = L_TOP - {lg_p_r[LOGN-1], lg_f_r[LOGN-1]};

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      dv_rem_r[0] <= 17'(dv_l[LW-1 -: 8]);
      dv_num_r[0] <= {dv_l[LW-9:0], 8'd0};
      dv_q_r[0]   <= '0;
      dv_d_r[0]   <= 17'(lg_e_r[LOGN-1]) + 17'd256;
    end
  end

  for (genvar g = 1; g <= LW; g++) begin : g_div
    logic [17:0] r2;
    logic        qb;
    assign r2 = {dv_rem_r[g-1], dv_num_r[g-1][LW-1]};
    assign qb = (r2 >= 18'(dv_d_r[g-1]));
    always_ff @(posedge clk) begin
      if (pipe_en) begin
        dv_rem_r[g] <= qb ? 17'(r2 - 18'(dv_d_r[g-1])) : r2[16:0];
        dv_num_r[g] <= dv_num_r[g-1] << 1;
        dv_q_r[g]   <= {dv_q_r[g-1][LW-2:0], qb};
        dv_d_r[g]   <= dv_d_r[g-1];
      end
    end
  end

  // Exp2 of the fraction, one conditional root multiply per stage.
  logic [30:0]   ex_v_r [EXPN];
  logic [29:0]   ex_f_r [EXPN];
  logic [PW-1:0] ex_n_r [EXPN];

  for (genvar g = 0; g < EXPN; g++) begin : g_exp
    localparam logic [30:0] RH = cpds_pkg::root_half(g + 1);
    logic [30:0]   v_in;
    logic [29:0]   f_in;
    logic [PW-1:0] n_in;
    logic [61:0]   pr;
    if (g == 0) begin : g_first
      assign v_in = ONE31;
      assign f_in = dv_q_r[LW][29:0];
      assign n_in = dv_q_r[LW][LW-1:30];
    end else begin : g_next
      assign v_in = ex_v_r[g-1];
      assign f_in = ex_f_r[g-1];
      assign n_in = ex_n_r[g-1];
    end
    assign pr = 62'(v_in) * 62'(RH) + (62'd1 << 29);
    always_ff @(posedge clk) begin
      if (pipe_en) begin
        ex_v_r[g] <= f_in[29-g] ? pr[60:30] : v_in;
        ex_f_r[g] <= f_in;
        ex_n_r[g] <= n_in;
      end
    end
  end

  // Round shift by the integer part, clamp to one.
  logic [31:0] sh_n;
  logic [31:0] sh_v;
  logic [30:0] cz_r;

  always_comb begin
    sh_n = 32'(ex_n_r[EXPN-1]);
    if (sh_n == 32'd0) begin
      sh_v = 32'(ex_v_r[EXPN-1]);
    end else if (sh_n > 32'd31) begin
      sh_v = '0;
    end else begin
      sh_v = (32'(ex_v_r[EXPN-1]) + (32'd1 << (sh_n - 32'd1))) >> sh_n;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      cz_r <= (sh_v > 32'(ONE31)) ? ONE31 : sh_v[30:0];
    end
  end

  // Radicand 1 - cos^2.
  logic [61:0] sq_czz;
  logic [60:0] sq_rad_r;
  logic [30:0] sq_cz_r;

  assign sq_czz = 62'(cz_r) * 62'(cz_r);

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sq_rad_r <= (61'd1 << 60) - sq_czz[60:0];
      sq_cz_r  <= cz_r;
    end
  end

  // Square root, one root bit per stage.
  logic [34:0] rt_rem_r  [RTN];
  logic [30:0] rt_root_r [RTN];
  logic [61:0] rt_rad_r  [RTN];
  logic [30:0] rt_cz_r   [RTN];

  for (genvar g = 0; g < RTN; g++) begin : g_rt
    logic [34:0] rem_in;
    logic [30:0] root_in;
    logic [61:0] rad_in;
    logic [30:0] cz_in;
    logic [34:0] r2;
    logic [34:0] t;
    logic        hit;
    if (g == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = {1'b0, sq_rad_r};
      assign cz_in   = sq_cz_r;
    end else begin : g_next
      assign rem_in  = rt_rem_r[g-1];
      assign root_in = rt_root_r[g-1];
      assign rad_in  = rt_rad_r[g-1];
      assign cz_in   = rt_cz_r[g-1];
    end
    assign r2  = {rem_in[32:0], rad_in[61:60]};
    assign t   = {2'b00, root_in, 2'b01};
    assign hit = (r2 >= t);
    always_ff @(posedge clk) begin
      if (pipe_en) begin
        rt_rem_r[g]  <= hit ? (r2 - t) : r2;
        rt_root_r[g] <= {root_in[29:0], hit};
        rt_rad_r[g]  <= rad_in << 2;
        rt_cz_r[g]   <= cz_in;
      end
    end
  end

  // Azimuth rotation: per bit of rx, a product stage and a round stage.
  logic signed [63:0] an_pcc_r [UB];
  logic signed [63:0] an_pss_r [UB];
  logic signed [63:0] an_pcs_r [UB];
  logic signed [63:0] an_psc_r [UB];
  logic signed [31:0] an_ca_r  [UB];
  logic signed [31:0] an_sa_r  [UB];
  logic               an_hit_r [UB];
  logic [UB-1:0]      an_rxa_r [UB];
  logic signed [31:0] an_c_r   [UB];
  logic signed [31:0] an_s_r   [UB];
  logic [UB-1:0]      an_rx_r  [UB];

  for (genvar g = 0; g < UB; g++) begin : g_ang
    localparam logic [63:0] TCW = cpds_pkg::turn_val(g + 1, 1'b0);
    localparam logic [63:0] TSW = cpds_pkg::turn_val(g + 1, 1'b1);
    localparam logic signed [31:0] TC = TCW[31:0];
    localparam logic signed [31:0] TS = TSW[31:0];
    logic signed [31:0] c_in;
    logic signed [31:0] s_in;
    logic [UB-1:0]      rx_in;
    logic signed [33:0] c_rnd;
    logic signed [33:0] s_rnd;
    if (g == 0) begin : g_first
      assign c_in  = 32'sd1 <<< 30;
      assign s_in  = '0;
      assign rx_in = rx0_r;
    end else begin : g_next
      assign c_in  = an_c_r[g-1];
      assign s_in  = an_s_r[g-1];
      assign rx_in = an_rx_r[g-1];
    end
    always_ff @(posedge clk) begin
      if (pipe_en) begin
        an_pcc_r[g] <= 64'(c_in) * 64'(TC);
        an_pss_r[g] <= 64'(s_in) * 64'(TS);
        an_pcs_r[g] <= 64'(c_in) * 64'(TS);
        an_psc_r[g] <= 64'(s_in) * 64'(TC);
        an_ca_r[g]  <= c_in;
        an_sa_r[g]  <= s_in;
        an_hit_r[g] <= rx_in[UB-1-g];
        an_rxa_r[g] <= rx_in;
      end
    end
    assign c_rnd = cpds_pkg::round_q30(an_pcc_r[g] - an_pss_r[g]);
    assign s_rnd = cpds_pkg::round_q30(an_pcs_r[g] + an_psc_r[g]);
    always_ff @(posedge clk) begin
      if (pipe_en) begin
        an_c_r[g]  <= an_hit_r[g] ? c_rnd[31:0] : an_ca_r[g];
        an_s_r[g]  <= an_hit_r[g] ? s_rnd[31:0] : an_sa_r[g];
        an_rx_r[g] <= an_rxa_r[g];
      end
    end
  end

  // Hold the angle until the sine leaves the root stages.
  logic signed [31:0] dl_c_r [ADLY];
  logic signed [31:0] dl_s_r [ADLY];

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      dl_c_r[0] <= an_c_r[UB-1];
      dl_s_r[0] <= an_s_r[UB-1];
      for (int i = 1; i < ADLY; i++) begin
        dl_c_r[i] <= dl_c_r[i-1];
        dl_s_r[i] <= dl_s_r[i-1];
      end
    end
  end

  // sin t times cos phi and sin phi, then rounding and saturation.
  logic signed [63:0] mu_st;
  logic signed [63:0] mu_x_r, mu_y_r;
  logic [30:0]        mu_cz_r;
  logic signed [33:0] rq_x_r, rq_y_r;
  logic [30:0]        rq_cz_r;
  logic [OB-1:0]      ox_r, oy_r;
  logic [OB-1:0]      oz_full;
  logic [OB-2:0]      oz_r;

  assign mu_st   = 64'(rt_root_r[RTN-1]);
  assign oz_full = to_out({3'b000, rq_cz_r});

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      mu_x_r  <= mu_st * 64'(dl_c_r[ADLY-1]);
      mu_y_r  <= mu_st * 64'(dl_s_r[ADLY-1]);
      mu_cz_r <= rt_cz_r[RTN-1];
      rq_x_r  <= cpds_pkg::round_q30(mu_x_r);
      rq_y_r  <= cpds_pkg::round_q30(mu_y_r);
      rq_cz_r <= mu_cz_r;
      ox_r    <= to_out(rq_x_r);
      oy_r    <= to_out(rq_y_r);
      oz_r    <= oz_full[OB-2:0];
    end
  end

  // Output skid: catch the last stage when the receiver stalls.
  logic [3*OB-2:0] pipe_res;
  logic [3*OB-2:0] skid_r;

  assign pipe_res = {oz_r, oy_r, ox_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_tready) skid_v_r <= 1'b0;
    end else if (v_r[N_OUT-1] && !out_tready) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v_r) begin
      skid_r <= pipe_res;
    end
  end

  assign out_tvalid = skid_v_r || v_r[N_OUT-1];
  assign out_tdata  = OUT_W'(skid_v_r ? skid_r : pipe_res);

endmodule
